FILE: rtl/pfbs_pkg.sv
// shared widths, codes and types of the piece-to-file block segmenter
`default_nettype none

package pfbs_pkg;

  localparam int DEF_MAX_FILES  = 16;
  localparam int DEF_BLOCK_SIZE = 16384;
  localparam int DEF_MAX_BLOCKS = 16;

  localparam int SIZE_W  = 48;
  localparam int PLEN_W  = 19;
  localparam int FCNT_W  = 5;
  localparam int PIDX_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int BEGIN_W = 18;
  localparam int LEN_W   = 15;
  localparam int PROD_W  = PLEN_W + PIDX_W;
  localparam int HALF_W  = PIDX_W / 2;

  localparam int MAX_RES = 32;
  localparam int NRES_W  = 6;

  localparam int IN_TDATA_W  = ((SLOT_W + SIZE_W + PIDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BEGIN_W + SLOT_W + SIZE_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_PLEN       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_COUNT = 1'd1;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 19'd262144;

  typedef struct packed {
    logic [PLEN_W-1:0] plen;
    logic [FCNT_W-1:0] file_count;
  } pfbs_cfg_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic [PIDX_W-1:0] pnum;
  } pfbs_item_t;

  typedef struct packed {
    logic               seg_valid;
    logic               block_end;
    logic               last;
    logic [BEGIN_W-1:0] block_begin;
    logic [SLOT_W-1:0]  slot;
    logic [SIZE_W-1:0]  file_offset;
    logic [LEN_W-1:0]   seg_len;
  } pfbs_res_t;

endpackage

`default_nettype wire

FILE: rtl/pfbs_size_mem.sv
// file size table, one write port and one registered read port
`default_nettype none

module pfbs_size_mem #(
  parameter int MAX_FILES = pfbs_pkg::DEF_MAX_FILES,
  localparam int AW = $clog2(MAX_FILES)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pfbs_pkg::SIZE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [pfbs_pkg::SIZE_W-1:0] rd_data
);
  import pfbs_pkg::*;

  logic [SIZE_W-1:0] mem [MAX_FILES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/pfbs_mul.sv
// piece start multiplier, two 19x16 partial products accumulated in turn
`default_nettype none

module pfbs_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfbs_pkg::PLEN_W-1:0] a,
  input  logic [pfbs_pkg::PIDX_W-1:0] b,
  output logic                        done,
  output logic [pfbs_pkg::PROD_W-1:0] product
);
  import pfbs_pkg::*;

  logic [PLEN_W-1:0]        a_r;
  logic [HALF_W-1:0]        b_hi;
  logic [PLEN_W+HALF_W-1:0] pp;
  logic [PROD_W-1:0]        acc;
  logic                     ph1;
  logic                     ph2;
  logic [PLEN_W-1:0]        mul_a;
  logic [HALF_W-1:0]        mul_b;

  assign mul_a   = start ? a : a_r;
  assign mul_b   = start ? b[HALF_W-1:0] : b_hi;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1  <= 1'b0;
      ph2  <= 1'b0;
      done <= 1'b0;
    end else begin
      ph1  <= start;
      ph2  <= ph1;
      done <= ph2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_hi <= b[PIDX_W-1:HALF_W];
    end
    pp <= mul_a * mul_b;
    if (ph1) begin
      acc <= PROD_W'(pp);
    end else if (ph2) begin
      acc <= acc + PROD_W'({pp, {HALF_W{1'b0}}});
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pfbs_walker.sv
// sequencer: table writes, piece start search and segment emission
`default_nettype none

module pfbs_walker #(
  parameter int MAX_FILES  = pfbs_pkg::DEF_MAX_FILES,
  parameter int BLOCK_SIZE = pfbs_pkg::DEF_BLOCK_SIZE,
  parameter int MAX_BLOCKS = pfbs_pkg::DEF_MAX_BLOCKS,
  localparam int AW = $clog2(MAX_FILES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pfbs_pkg::pfbs_item_t        in_item,
  input  pfbs_pkg::pfbs_cfg_t         cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfbs_pkg::pfbs_res_t         out_res,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [pfbs_pkg::SIZE_W-1:0] mem_wr_data,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [pfbs_pkg::SIZE_W-1:0] mem_rd_data,
  output logic                        mul_start,
  output logic [pfbs_pkg::PLEN_W-1:0] mul_a,
  output logic [pfbs_pkg::PIDX_W-1:0] mul_b,
  input  logic                        mul_done,
  input  logic [pfbs_pkg::PROD_W-1:0] mul_product
);
  import pfbs_pkg::*;

  localparam int CW       = $clog2(MAX_FILES + 1);
  localparam int CUR_W    = $clog2(BLOCK_SIZE + 1);
  localparam int PLEN_CAP = MAX_BLOCKS * BLOCK_SIZE;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_SKIPZ  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     idx, idx_next;
  logic [PROD_W-1:0] skip, skip_next;
  logic [SIZE_W-1:0] off, off_next;
  logic [PLEN_W-1:0] left, left_next;
  logic [CUR_W-1:0]  cur, cur_next;
  logic [PLEN_W-1:0] blk_begin, blk_begin_next;
  logic [NRES_W-1:0] nres, nres_next;
  logic              close_r, close_next;
  pfbs_res_t         res_next;
  logic              out_valid_next;

  logic [PLEN_W-1:0] plen_cl;
  logic [CW-1:0]     cnt_cl;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] avail;
  logic [PLEN_W-1:0] bs_room;
  logic [PLEN_W-1:0] room;
  logic              exhaust;
  logic [PLEN_W-1:0] take;
  logic [PLEN_W-1:0] left_dec;
  logic [NRES_W-1:0] nres_inc;
  logic [CW-1:0]     idx_inc;
  logic              out_free;
  logic              accept;
  logic              is_last;

  assign plen_cl = (int'(cfg.plen) > PLEN_CAP) ? PLEN_W'(PLEN_CAP) : cfg.plen;
  assign cnt_cl  = (int'(cfg.file_count) > MAX_FILES) ? CW'(MAX_FILES) : CW'(cfg.file_count);

  assign size     = mem_rd_data;
  assign avail    = size - off;
  assign bs_room  = PLEN_W'(BLOCK_SIZE) - PLEN_W'(cur);
  assign room     = (left < bs_room) ? left : bs_room;
  assign exhaust  = (avail <= SIZE_W'(room));
  assign take     = exhaust ? avail[PLEN_W-1:0] : room;
  assign left_dec = left - take;
  assign nres_inc = nres + NRES_W'(1);
  assign idx_inc  = idx + CW'(1);
  assign out_free = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign mul_start = accept && (in_item.kind == KIND_REQUEST);
  assign mul_a     = plen_cl;
  assign mul_b     = in_item.pnum;

  assign mem_wr_en   = accept && (in_item.kind == KIND_LOAD) &&
                       (32'(in_item.slot) < MAX_FILES);
  assign mem_wr_addr = AW'(in_item.slot);
  assign mem_wr_data = in_item.size;
  assign mem_rd_addr = idx_next[AW-1:0];

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    skip_next      = skip;
    off_next       = off;
    left_next      = left;
    cur_next       = cur;
    blk_begin_next = blk_begin;
    nres_next      = nres;
    close_next     = close_r;
    res_next       = out_res;
    out_valid_next = out_valid && !out_ready;
    is_last        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept && in_item.kind == KIND_REQUEST) begin
          cnt_next       = cnt_cl;
          left_next      = plen_cl;
          cur_next       = '0;
          blk_begin_next = '0;
          nres_next      = '0;
          idx_next       = '0;
          off_next       = '0;
          state_next     = ST_MUL;
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          skip_next  = mul_product;
          state_next = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (idx >= cnt) begin
          state_next = ST_EMIT;
        end else if (skip == '0) begin
          if (size == '0) begin
            idx_next = idx_inc;
          end else begin
            state_next = ST_EMIT;
          end
        end else if (PROD_W'(size) > skip) begin
          off_next   = skip[SIZE_W-1:0];
          skip_next  = '0;
          state_next = ST_EMIT;
        end else begin
          skip_next = skip - PROD_W'(size);
          idx_next  = idx_inc;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          if (left == '0 || idx >= cnt) begin
            // piece lies beyond the stored data or has zero length
            res_next       = '0;
            res_next.last  = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            res_next.seg_valid   = 1'b1;
            res_next.block_begin = blk_begin[BEGIN_W-1:0];
            res_next.slot        = SLOT_W'(idx);
            res_next.file_offset = off;
            res_next.seg_len     = take[LEN_W-1:0];
            left_next            = left_dec;
            nres_next            = nres_inc;
            if (take == room) begin
              cur_next       = '0;
              blk_begin_next = blk_begin + PLEN_W'(BLOCK_SIZE);
            end else begin
              cur_next = cur + CUR_W'(take);
            end
            if (!exhaust) begin
              is_last            = (left_dec == '0) || (nres_inc == NRES_W'(MAX_RES));
              off_next           = off + SIZE_W'(take);
              res_next.block_end = 1'b1;
              res_next.last      = is_last;
              out_valid_next     = 1'b1;
              state_next         = is_last ? ST_IDLE : ST_EMIT;
            end else begin
              // file used up, skip empty files before closing the segment
              idx_next           = idx_inc;
              off_next           = '0;
              close_next         = (take == room);
              res_next.block_end = 1'b0;
              res_next.last      = 1'b0;
              state_next         = ST_SKIPZ;
            end
          end
        end
      end

      ST_SKIPZ: begin
        if (idx < cnt && size == '0) begin
          idx_next = idx_inc;
        end else begin
          is_last            = (left == '0) || (idx >= cnt) || (nres == NRES_W'(MAX_RES));
          res_next.block_end = close_r || (idx >= cnt);
          res_next.last      = is_last;
          out_valid_next     = 1'b1;
          state_next         = is_last ? ST_IDLE : ST_EMIT;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    idx       <= idx_next;
    skip      <= skip_next;
    off       <= off_next;
    left      <= left_next;
    cur       <= cur_next;
    blk_begin <= blk_begin_next;
    nres      <= nres_next;
    close_r   <= close_next;
    out_res   <= res_next;
  end

endmodule

`default_nettype wire

FILE: rtl/piece_to_file_block_segmenter_top.sv
// top level of the piece-to-file block segmenter
`default_nettype none

// Keeps a table of file sizes laid end to end and turns a piece request into
// block requests split at file boundaries. A load item writes one table entry.
// A request runs the piece start multiply, settles the start, steps over
// table entries (entries passed while finding the start, entries used up by a
// segment and empty entries skipped) and emits its segments; the single read
// port of the size table sets the walk. The next item is taken once the final
// result of a request sits in the output register. The user must write
// settings through the cfg port only while no request is active; the block
// itself does not enforce this.
module piece_to_file_block_segmenter_top #(
  parameter int MAX_FILES  = pfbs_pkg::DEF_MAX_FILES,
  parameter int BLOCK_SIZE = pfbs_pkg::DEF_BLOCK_SIZE,
  parameter int MAX_BLOCKS = pfbs_pkg::DEF_MAX_BLOCKS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // file_slot, file_size, piece_num
  input  logic [pfbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // block_begin, out_file_slot, file_offset, segment_length
  output logic [pfbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // segment_valid, block_end
  output logic [pfbs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pfbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfbs_pkg::PLEN_W-1:0]      cfg_data
);
  import pfbs_pkg::*;

  localparam int AW = $clog2(MAX_FILES);

  pfbs_cfg_t         cfg;
  pfbs_item_t        in_item;
  pfbs_res_t         res;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [SIZE_W-1:0] mem_wr_data;
  logic [AW-1:0]     mem_rd_addr;
  logic [SIZE_W-1:0] mem_rd_data;
  logic              mul_start;
  logic [PLEN_W-1:0] mul_a;
  logic [PIDX_W-1:0] mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_product;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plen       <= PLEN_RESET;
      cfg.file_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PLEN:       cfg.plen       <= cfg_data;
        CFG_FILE_COUNT: cfg.file_count <= cfg_data[FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.kind = s_axis_tuser;
  assign in_item.slot = s_axis_tdata[SLOT_W-1:0];
  assign in_item.size = s_axis_tdata[SLOT_W +: SIZE_W];
  assign in_item.pnum = s_axis_tdata[SLOT_W+SIZE_W +: PIDX_W];

  assign m_axis_tdata = OUT_TDATA_W'({res.seg_len, res.file_offset, res.slot,
                                      res.block_begin});
  assign m_axis_tuser = {res.block_end, res.seg_valid};
  assign m_axis_tlast = res.last;

  pfbs_size_mem #(
    .MAX_FILES (MAX_FILES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  pfbs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  pfbs_walker #(
    .MAX_FILES  (MAX_FILES),
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_item     (in_item),
    .cfg         (cfg),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mul_start   (mul_start),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_done    (mul_done),
    .mul_product (mul_product)
  );

endmodule

`default_nettype wire

FILE: rtl/pfbs_checker.sv
// port-level checks of the segmenter and their bind to the top level
`default_nettype none

module pfbs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pfbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [pfbs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                             m_axis_tlast
);
  import pfbs_pkg::*;

  // a request keeps the input closed while its start is computed
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_REQUEST |=> !s_axis_tready)
    else $error("input taken right after a request");

  // a result not taken stays unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a piece without data gives one closing all-zero result
  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && !m_axis_tuser[1] && m_axis_tdata == '0)
    else $error("invalid result malformed");

  // a table load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_LOAD && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result after a table load");

endmodule

bind piece_to_file_block_segmenter_top pfbs_checker u_pfbs_checker (.*);

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// testbench for the piece-to-file block segmenter, checked against a predictor
module tb;
  import pfbs_pkg::*;

  localparam int N_FILES = DEF_MAX_FILES;
  localparam longint unsigned BLK = DEF_BLOCK_SIZE;
  localparam longint unsigned PLEN_MAX = DEF_MAX_BLOCKS * DEF_BLOCK_SIZE;
  localparam int IDLE_PAUSE = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {SIZES_MIXED, SIZES_SMALL} size_profile_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PLEN_W-1:0] cfg_data = '0;

  piece_to_file_block_segmenter_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [SIZE_W-1:0] size_tbl [N_FILES];
  logic [PLEN_W-1:0] cur_plen = PLEN_RESET;
  logic [FCNT_W-1:0] cur_fcnt = '0;
  pfbs_res_t exp_segments [$];

  // stimulus side
  logic [SIZE_W-1:0] gen_tbl [N_FILES];
  pfbs_item_t send_q [$];
  pfbs_item_t cur_item;
  int n_queued = 0;
  int n_accepted = 0;
  int n_loads = 0;
  int n_requests = 0;
  int n_writes = 0;
  int n_checked = 0;
  int err_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;
  int quiet = 0;

  task automatic segment_piece(input logic [PIDX_W-1:0] pidx);
    longint unsigned cnt, plen, skip, idx, off, left, base, lim, cur, avail, room, take;
    longint unsigned start, slot_n;
    int n;
    pfbs_res_t held;
    cnt = (cur_fcnt > N_FILES) ? N_FILES : cur_fcnt;
    plen = (cur_plen > PLEN_MAX) ? PLEN_MAX : cur_plen;
    skip = plen * pidx;
    idx = 0;
    off = 0;
    n = 0;
    held = '0;
    // find the file holding the piece start
    while (skip > 0 && idx < cnt) begin
      if (size_tbl[idx] > skip) begin
        off = skip;
        skip = 0;
      end else begin
        skip -= size_tbl[idx];
        idx++;
      end
    end
    if (skip > 0) idx = cnt;
    while (idx < cnt && size_tbl[idx] == 0) idx++;
    left = plen;
    while (left > 0 && idx < cnt && n < MAX_RES) begin
      base = plen - left;
      lim = (left < BLK) ? left : BLK;
      cur = 0;
      while (cur < lim && idx < cnt && n < MAX_RES) begin
        avail = size_tbl[idx] - off;
        room = lim - cur;
        slot_n = idx;
        start = off;
        if (avail > room) begin
          take = room;
          off += take;
        end else begin
          take = avail;
          idx++;
          off = 0;
          while (idx < cnt && size_tbl[idx] == 0) idx++;
        end
        left -= take;
        cur += take;
        if (n > 0) exp_segments.push_back(held);
        held.seg_valid = 1'b1;
        held.block_begin = base[BEGIN_W-1:0];
        held.slot = slot_n[SLOT_W-1:0];
        held.file_offset = start[SIZE_W-1:0];
        held.seg_len = take[LEN_W-1:0];
        held.block_end = (cur == lim || idx >= cnt);
        held.last = 1'b0;
        n++;
      end
    end
    if (n == 0) held = '0;
    held.last = 1'b1;
    exp_segments.push_back(held);
  endtask

  task automatic report_miss(input string what, input pfbs_res_t want, input pfbs_res_t got);
    if (err_cnt < 10)
      $display("%s: exp v=%0d bb=%0d slot=%0d off=%0d len=%0d be=%0d last=%0d",
               what, want.seg_valid, want.block_begin, want.slot, want.file_offset,
               want.seg_len, want.block_end, want.last,
               " | got v=%0d bb=%0d slot=%0d off=%0d len=%0d be=%0d last=%0d",
               got.seg_valid, got.block_begin, got.slot, got.file_offset,
               got.seg_len, got.block_end, got.last);
    err_cnt++;
  endtask

  function automatic logic [SIZE_W-1:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom};
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input size_profile_t prof);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (prof == SIZES_SMALL) return $urandom_range(1, 3000);
    case (sel)
      1, 2, 3, 4: return $urandom_range(1, 40000);
      5, 6: return $urandom_range(1, 2000);
      7: return $urandom_range(1, 1 << 22);
      default: return rand48();
    endcase
  endfunction

  // index inside or just past the stored data
  function automatic logic [PIDX_W-1:0] pick_index();
    longint unsigned total, plen, pieces, cnt;
    cnt = (cur_fcnt > N_FILES) ? N_FILES : cur_fcnt;
    plen = (cur_plen > PLEN_MAX) ? PLEN_MAX : cur_plen;
    total = 0;
    for (int i = 0; i < cnt; i++) total += gen_tbl[i];
    if (plen == 0) return $urandom;
    pieces = total / plen;
    if (pieces >= 64'hFFFF_FFF0) return $urandom;
    return $urandom_range(0, 32'(pieces + 1));
  endfunction

  task automatic queue_item(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [SIZE_W-1:0] size, input logic [PIDX_W-1:0] pidx);
    pfbs_item_t it;
    it.kind = kind;
    it.slot = slot;
    it.size = size;
    it.pnum = pidx;
    send_q.push_back(it);
    n_queued++;
    if (kind == KIND_LOAD) gen_tbl[slot] = size;
  endtask

  task automatic load_file(input int slot, input logic [SIZE_W-1:0] size);
    queue_item(KIND_LOAD, SLOT_W'(slot), size, $urandom);
  endtask

  task automatic request_piece(input logic [PIDX_W-1:0] pidx);
    queue_item(KIND_REQUEST, SLOT_W'($urandom_range(0, N_FILES - 1)), rand48(), pidx);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= PLEN_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PLEN) cur_plen = PLEN_W'(val);
    else cur_fcnt = FCNT_W'(val);
    n_writes++;
  endtask

  task automatic settle();
    do @(posedge clk); while (n_accepted != n_queued || exp_segments.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic random_phase(input longint unsigned plen, input longint unsigned fcnt,
                              input size_profile_t prof, input int nitems);
    int unsigned sel;
    write_reg(CFG_PLEN, plen);
    write_reg(CFG_FILE_COUNT, fcnt);
    if (prof == SIZES_SMALL)
      for (int s = 0; s < N_FILES; s++) load_file(s, pick_size(prof));
    repeat (nitems) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) load_file($urandom_range(0, N_FILES - 1), pick_size(prof));
      else if (sel == 2) request_piece($urandom);
      else request_piece(pick_index());
    end
    settle();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_accepted++;
        if (cur_item.kind == KIND_LOAD) begin
          size_tbl[cur_item.slot] = cur_item.size;
          n_loads++;
        end else begin
          segment_piece(cur_item.pnum);
          n_requests++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (send_q.size() != 0) begin
          cur_item = send_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_item.kind;
          s_axis_tdata <= IN_TDATA_W'({cur_item.pnum, cur_item.size, cur_item.slot});
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((cyc % 7) < 3);
    endcase
  end

  // segment monitor
  always @(posedge clk) begin
    pfbs_res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.seg_valid = m_axis_tuser[0];
      got.block_end = m_axis_tuser[1];
      got.last = m_axis_tlast;
      got.block_begin = m_axis_tdata[BEGIN_W-1:0];
      got.slot = m_axis_tdata[BEGIN_W +: SLOT_W];
      got.file_offset = m_axis_tdata[BEGIN_W + SLOT_W +: SIZE_W];
      got.seg_len = m_axis_tdata[BEGIN_W + SLOT_W + SIZE_W +: LEN_W];
      if (exp_segments.size() == 0) begin
        report_miss("unexpected segment", '0, got);
      end else begin
        want = exp_segments.pop_front();
        n_checked++;
        if (got !== want) report_miss("segment mismatch", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", quiet);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < N_FILES; s++) begin
      size_tbl[s] = '0;
      gen_tbl[s] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: no files in use
    request_piece(0);
    for (int s = 0; s < N_FILES; s++)
      case (s)
        0: load_file(s, 20000);
        1, 5: load_file(s, 0);
        2: load_file(s, 5000);
        3: load_file(s, 1);
        4: load_file(s, 30000);
        6: load_file(s, BLK);
        default: load_file(s, 3000);
      endcase
    settle();

    // data ends inside the piece, piece past the data
    write_reg(CFG_FILE_COUNT, N_FILES);
    request_piece(0);
    request_piece(1);
    request_piece('1);
    settle();

    write_reg(CFG_PLEN, BLK);
    request_piece(0);
    request_piece(5);
    settle();

    write_reg(CFG_PLEN, 1);
    request_piece(20000);
    settle();

    // zero piece length
    write_reg(CFG_PLEN, 0);
    request_piece(3);
    settle();

    // oversized piece length and file count
    write_reg(CFG_PLEN, '1);
    write_reg(CFG_FILE_COUNT, 31);
    request_piece(0);
    settle();

    write_reg(CFG_FILE_COUNT, 1);
    request_piece(1);
    settle();

    random_phase(PLEN_RESET, N_FILES, SIZES_SMALL, 16);
    random_phase(BLK, N_FILES, SIZES_MIXED, 20);
    random_phase($urandom_range(1, PLEN_MAX), $urandom_range(1, N_FILES), SIZES_MIXED, 20);
    random_phase('1, 17, SIZES_SMALL, 16);
    random_phase(1, N_FILES, SIZES_MIXED, 20);
    random_phase($urandom_range(512, 65536), 31, SIZES_MIXED, 20);

    if (exp_segments.size() != 0) begin
      $display("%0d segments never arrived", exp_segments.size());
      err_cnt += exp_segments.size();
    end
    $display("ran %0d piece requests and %0d size loads over %0d register writes",
             n_requests, n_loads, n_writes);
    $display("checked %0d segments, %0d errors", n_checked, err_cnt);
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
